FILE: rtl/core/srlp_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the steering rate-limited projection block:
// status codes, register indexes, reset values and fixed field widths.
package srlp_pkg;

   localparam int RATE_BITS      = 16;
   localparam int FRAC_BITS      = 13;
   localparam int STATUS_BITS    = 3;
   localparam int CSR_INDEX_BITS = 2;

   typedef logic [STATUS_BITS-1:0]    status_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   typedef logic [RATE_BITS-1:0]      rate_type;

   localparam status_type STATUS_OK          = 3'd0;
   localparam status_type STATUS_NO_COMMAND  = 3'd1;
   localparam status_type STATUS_BAD_MEASURE = 3'd2;
   localparam status_type STATUS_BAD_TIMING  = 3'd3;
   localparam status_type STATUS_STALE       = 3'd4;
   localparam status_type STATUS_BAD_LIMITS  = 3'd5;

   localparam csr_index_type CSR_MAX_ABS_STEERING    = 2'd0;
   localparam csr_index_type CSR_MAX_OBSERVATION_AGE = 2'd1;
   localparam csr_index_type CSR_MAX_STEERING_RATE   = 2'd2;

   localparam int MAX_ABS_STEERING_RESET    = 8192;
   localparam int MAX_OBSERVATION_AGE_RESET = 6554;
   localparam int MAX_STEERING_RATE_RESET   = 1024;

endpackage

FILE: rtl/core/srlp_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request, response and CSR write ports.
// Depends on srlp_pkg for the status, index and rate widths.
interface srlp_req_if #(
   parameter int ANGLE_BITS = 16,
   parameter int TIME_BITS  = 24
);
   logic                         valid;
   logic                         ready;
   logic signed [ANGLE_BITS-1:0] measured_angle;
   logic signed [ANGLE_BITS-1:0] committed_angle;
   logic                         committed_present;
   logic signed [TIME_BITS-1:0]  observation_age;
   logic signed [TIME_BITS-1:0]  prediction_delay;
   logic signed [TIME_BITS-1:0]  command_age;
   logic signed [TIME_BITS-1:0]  command_control_age;

   modport source (
      output valid, measured_angle, committed_angle, committed_present,
             observation_age, prediction_delay, command_age, command_control_age,
      input  ready
   );
   modport sink (
      input  valid, measured_angle, committed_angle, committed_present,
             observation_age, prediction_delay, command_age, command_control_age,
      output ready
   );
endinterface

interface srlp_rsp_if #(
   parameter int ANGLE_BITS = 16,
   parameter int TIME_BITS  = 24
);
   logic                         valid;
   logic                         ready;
   srlp_pkg::status_type         status;
   logic signed [ANGLE_BITS-1:0] measured_clamped;
   logic signed [ANGLE_BITS-1:0] committed_clamped;
   logic signed [ANGLE_BITS-1:0] current_angle;
   logic signed [ANGLE_BITS-1:0] origin_angle;
   logic                         command_reached;
   logic [TIME_BITS-2:0]         command_projection_time;
   logic [TIME_BITS-2:0]         projection_time;
   logic [ANGLE_BITS:0]          max_reachable_step;

   modport source (
      output valid, status, measured_clamped, committed_clamped, current_angle,
             origin_angle, command_reached, command_projection_time,
             projection_time, max_reachable_step,
      input  ready
   );
   modport sink (
      input  valid, status, measured_clamped, committed_clamped, current_angle,
             origin_angle, command_reached, command_projection_time,
             projection_time, max_reachable_step,
      output ready
   );
endinterface

interface srlp_csr_if #(
   parameter int ANGLE_BITS = 16,
   parameter int TIME_BITS  = 24
);
   localparam int W0     = ANGLE_BITS - 1;
   localparam int W1     = TIME_BITS - 1;
   localparam int W01    = (W0 > W1) ? W0 : W1;
   localparam int DATA_W = (W01 > srlp_pkg::RATE_BITS) ? W01 : srlp_pkg::RATE_BITS;

   logic                    valid;
   logic                    ready;
   srlp_pkg::csr_index_type index;
   logic [DATA_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/srlp_reach.sv
`timescale 1ns / 1ps
// Slew-limited step: rate times duration bound, step toward the target, clamp to limit.
// Depends on srlp_pkg for the rate width and the angle fraction bits.
module srlp_reach #(
   parameter int ANGLE_BITS = 16,
   parameter int TIME_BITS  = 24
) (
   input  srlp_pkg::rate_type            rate,
   input  logic [TIME_BITS-2:0]          duration,
   input  logic signed [ANGLE_BITS-1:0]  base_angle,
   input  logic signed [ANGLE_BITS:0]    req_step,
   input  logic [ANGLE_BITS-2:0]         limit,
   output logic [ANGLE_BITS:0]           bound,
   output logic signed [ANGLE_BITS-1:0]  angle,
   output logic                          fits
);
   import srlp_pkg::*;

   localparam int PW = RATE_BITS + TIME_BITS - 1;
   localparam int SW = PW - FRAC_BITS;
   localparam int CW = ANGLE_BITS + 1;
   localparam int XW = (SW > CW) ? SW : CW;
   localparam int DW = ANGLE_BITS + 3;
   localparam logic [CW-1:0] BOUND_CAP = '1;

   logic [PW-1:0]        product;
   logic [XW-1:0]        shifted;
   logic signed [DW-1:0] req_d;
   logic signed [DW-1:0] abs_req;
   logic signed [DW-1:0] bound_d;
   logic signed [DW-1:0] lim_d;
   logic signed [DW-1:0] step_d;
   logic signed [DW-1:0] sum_d;

   assign product = PW'(rate) * PW'(duration);
   assign shifted = XW'(product[PW-1:FRAC_BITS]);
   assign bound   = (shifted > XW'(BOUND_CAP)) ? BOUND_CAP : shifted[CW-1:0];

   assign req_d   = DW'(req_step);
   assign abs_req = req_d[DW-1] ? -req_d : req_d;
   assign bound_d = $signed(DW'(bound));
   assign lim_d   = $signed(DW'(limit));
   assign fits    = (abs_req <= bound_d);

   always_comb begin
      if (fits) begin
         step_d = req_d;
      end else if (req_d[DW-1]) begin
         step_d = -bound_d;
      end else begin
         step_d = bound_d;
      end
      sum_d = DW'(base_angle) + step_d;
      priority if (sum_d > lim_d) begin
         angle = ANGLE_BITS'(lim_d);
      end else if (sum_d < -lim_d) begin
         angle = ANGLE_BITS'(-lim_d);
      end else begin
         angle = ANGLE_BITS'(sum_d);
      end
   end

endmodule

FILE: rtl/core/steering_rate_limited_projection_top.sv
`timescale 1ns / 1ps
// Path: a transaction accepted into the request register moves on to the result register, which drives rsp.
// Throughput: one transaction per cycle; the request register and the result
// register form a two-deep pipeline that advances whenever the result is taken or empty.
// The input-to-result path holds the two 16 x (TIME_BITS-1) rate multiplies.
// Reset: synchronous, clears both pipeline valids and loads the CSR reset values.
module steering_rate_limited_projection_top #(
   parameter int ANGLE_BITS = 16,
   parameter int TIME_BITS  = 24
) (
   input  logic       clock,
   input  logic       reset,
   srlp_req_if.sink   req,
   srlp_rsp_if.source rsp,
   srlp_csr_if.sink   csr
);
   import srlp_pkg::*;

   localparam int A = ANGLE_BITS;
   localparam int T = TIME_BITS;

   // CSRs
   logic [A-2:0]  max_abs_ff, max_abs_in;
   logic [T-2:0]  max_obs_ff, max_obs_in;
   rate_type      max_rate_ff, max_rate_in;
   logic          csr_write;

   assign csr.ready = 1'b1;
   assign csr_write = csr.valid & csr.ready;

   always_comb begin
      max_abs_in  = max_abs_ff;
      max_obs_in  = max_obs_ff;
      max_rate_in = max_rate_ff;
      if (csr_write) begin
         unique case (csr.index)
            CSR_MAX_ABS_STEERING:    max_abs_in  = csr.data[A-2:0];
            CSR_MAX_OBSERVATION_AGE: max_obs_in  = csr.data[T-2:0];
            CSR_MAX_STEERING_RATE:   max_rate_in = csr.data[RATE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_abs_ff  <= (A-1)'(MAX_ABS_STEERING_RESET);
         max_obs_ff  <= (T-1)'(MAX_OBSERVATION_AGE_RESET);
         max_rate_ff <= RATE_BITS'(MAX_STEERING_RATE_RESET);
      end else begin
         max_abs_ff  <= max_abs_in;
         max_obs_ff  <= max_obs_in;
         max_rate_ff <= max_rate_in;
      end
   end

   // Pipeline control
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s2_open;
   logic s1_move;
   logic req_take;

   assign s2_open   = ~s2_valid_ff | rsp.ready;
   assign s1_move   = s1_valid_ff & s2_open;
   assign req.ready = ~s1_valid_ff | s2_open;
   assign req_take  = req.valid & req.ready;

   always_comb begin
      s1_valid_in = req_take ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      s2_valid_in = s1_move ? 1'b1 : (rsp.ready ? 1'b0 : s2_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Request register
   logic signed [A-1:0] meas_ff, comm_ff;
   logic                present_ff;
   logic signed [T-1:0] obs_ff, delay_ff, cmd_ff, ctl_ff;

   always_ff @(posedge clock) begin
      if (req_take) begin
         meas_ff    <= req.measured_angle;
         comm_ff    <= req.committed_angle;
         present_ff <= req.committed_present;
         obs_ff     <= req.observation_age;
         delay_ff   <= req.prediction_delay;
         cmd_ff     <= req.command_age;
         ctl_ff     <= req.command_control_age;
      end
   end

   // Checks
   logic [A-1:0] meas_abs, comm_abs;
   status_type   status;

   assign meas_abs = meas_ff[A-1] ? A'(-meas_ff) : A'(meas_ff);
   assign comm_abs = comm_ff[A-1] ? A'(-comm_ff) : A'(comm_ff);

   always_comb begin
      priority if (!present_ff) begin
         status = STATUS_NO_COMMAND;
      end else if (obs_ff[T-1] || delay_ff[T-1]) begin
         status = STATUS_BAD_TIMING;
      end else if (max_obs_ff == '0 || max_abs_ff == '0 || cmd_ff[T-1] || ctl_ff[T-1]) begin
         status = STATUS_BAD_LIMITS;
      end else if (meas_abs > A'(max_abs_ff) || comm_abs > A'(max_abs_ff)) begin
         status = STATUS_BAD_MEASURE;
      end else if (obs_ff[T-2:0] > max_obs_ff) begin
         status = STATUS_STALE;
      end else begin
         status = STATUS_OK;
      end
   end

   // Projection
   logic [T-2:0]        cpt;
   logic [T-1:0]        pt_sum;
   logic [T-2:0]        pt;
   logic signed [A:0]   req_diff;
   logic [A:0]          cur_bound, reach;
   logic signed [A-1:0] cur_angle, org_angle;
   logic                cur_fits, org_fits;

   assign cpt      = (obs_ff[T-2:0] < cmd_ff[T-2:0]) ? obs_ff[T-2:0] : cmd_ff[T-2:0];
   assign pt_sum   = T'(cpt) + T'(delay_ff[T-2:0]);
   assign pt       = pt_sum[T-1] ? '1 : pt_sum[T-2:0];
   assign req_diff = (A+1)'(comm_ff) - (A+1)'(meas_ff);

   srlp_reach #(.ANGLE_BITS(A), .TIME_BITS(T)) u_reach_current (
      .rate       (max_rate_ff),
      .duration   (cpt),
      .base_angle (meas_ff),
      .req_step   (req_diff),
      .limit      (max_abs_ff),
      .bound      (cur_bound),
      .angle      (cur_angle),
      .fits       (cur_fits)
   );

   srlp_reach #(.ANGLE_BITS(A), .TIME_BITS(T)) u_reach_origin (
      .rate       (max_rate_ff),
      .duration   (pt),
      .base_angle (meas_ff),
      .req_step   (req_diff),
      .limit      (max_abs_ff),
      .bound      (reach),
      .angle      (org_angle),
      .fits       (org_fits)
   );

   // Result register
   status_type          status_ff;
   logic signed [A-1:0] meas_out_ff, comm_out_ff, cur_out_ff, org_out_ff;
   logic                reached_ff;
   logic [T-2:0]        cpt_ff, pt_ff;
   logic [A:0]          reach_ff;
   logic                ok;

   assign ok = (status == STATUS_OK);

   always_ff @(posedge clock) begin
      if (s1_move) begin
         status_ff   <= status;
         meas_out_ff <= ok ? meas_ff : '0;
         comm_out_ff <= ok ? comm_ff : '0;
         cur_out_ff  <= ok ? cur_angle : '0;
         org_out_ff  <= ok ? org_angle : '0;
         reached_ff  <= ok & org_fits;
         cpt_ff      <= ok ? cpt : '0;
         pt_ff       <= ok ? pt : '0;
         reach_ff    <= ok ? reach : '0;
      end
   end

   assign rsp.valid                   = s2_valid_ff;
   assign rsp.status                  = status_ff;
   assign rsp.measured_clamped        = meas_out_ff;
   assign rsp.committed_clamped       = comm_out_ff;
   assign rsp.current_angle           = cur_out_ff;
   assign rsp.origin_angle            = org_out_ff;
   assign rsp.command_reached         = reached_ff;
   assign rsp.command_projection_time = cpt_ff;
   assign rsp.projection_time         = pt_ff;
   assign rsp.max_reachable_step      = reach_ff;

   logic unused_bits;
   assign unused_bits = cur_fits | (|cur_bound);

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for steering_rate_limited_projection_top: random and directed steering
// samples through the req/rsp/csr channels against an in-bench projection model.
// Depends on srlp_pkg, the srlp channel interfaces and the top-level RTL.
module tb;
   import srlp_pkg::*;

   localparam int ANGLE_BITS    = 16;
   localparam int TIME_BITS     = 24;
   localparam int CLOCK_PERIOD  = 8;
   localparam int ANGLE_MAX     = 2 ** (ANGLE_BITS - 1) - 1;
   localparam int TIME_MAX      = 2 ** (TIME_BITS - 1) - 1;
   localparam longint STEP_MAX  = 2 ** (ANGLE_BITS + 1) - 1;
   localparam int W01           = (ANGLE_BITS - 1 > TIME_BITS - 1) ? ANGLE_BITS - 1
                                                                    : TIME_BITS - 1;
   localparam int CSR_DATA_BITS = (W01 > RATE_BITS) ? W01 : RATE_BITS;
   localparam int LONG_HOLD     = 300;
   localparam csr_index_type CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [ANGLE_BITS-1:0] measured;
      logic [ANGLE_BITS-1:0] committed;
      logic                  present;
      logic [TIME_BITS-1:0]  obs_age;
      logic [TIME_BITS-1:0]  delay;
      logic [TIME_BITS-1:0]  cmd_age;
      logic [TIME_BITS-1:0]  ctl_age;
   } steer_sample_type;

   typedef struct packed {
      status_type            status;
      logic [ANGLE_BITS-1:0] measured_clamped;
      logic [ANGLE_BITS-1:0] committed_clamped;
      logic [ANGLE_BITS-1:0] current_angle;
      logic [ANGLE_BITS-1:0] origin_angle;
      logic                  command_reached;
      logic [TIME_BITS-2:0]  command_projection_time;
      logic [TIME_BITS-2:0]  projection_time;
      logic [ANGLE_BITS:0]   max_reachable_step;
   } projection_type;

   typedef enum int {
      BREAK_ABSENT, BREAK_OBS_NEG, BREAK_DELAY_NEG, BREAK_CMD_NEG,
      BREAK_CTL_NEG, BREAK_ANGLE, BREAK_STALE
   } break_kind_type;

   logic clock = 1'b0;
   logic reset;

   srlp_req_if #(.ANGLE_BITS(ANGLE_BITS), .TIME_BITS(TIME_BITS)) req_if ();
   srlp_rsp_if #(.ANGLE_BITS(ANGLE_BITS), .TIME_BITS(TIME_BITS)) rsp_if ();
   srlp_csr_if #(.ANGLE_BITS(ANGLE_BITS), .TIME_BITS(TIME_BITS)) csr_if ();

   steering_rate_limited_projection_top #(
      .ANGLE_BITS(ANGLE_BITS),
      .TIME_BITS (TIME_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req  (req_if),
      .rsp  (rsp_if),
      .csr  (csr_if)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   steer_sample_type sample_q[$];
   projection_type   projection_q[$];
   steer_sample_type offered;

   logic [ANGLE_BITS-2:0] lim_cfg  = (ANGLE_BITS - 1)'(MAX_ABS_STEERING_RESET);
   logic [TIME_BITS-2:0]  age_cfg  = (TIME_BITS - 1)'(MAX_OBSERVATION_AGE_RESET);
   rate_type              rate_cfg = RATE_BITS'(MAX_STEERING_RATE_RESET);

   int faults        = 0;
   int send_idle_pct = 0;
   int take_idle_pct = 0;
   bit calm          = 1'b0;
   int long_hold_req = 0;
   int long_hold_seen;
   int long_hold_left;
   int send_gap;
   int take_gap;

   function automatic longint clamp_mag(input longint v, input longint m);
      if (v > m) return m;
      if (v < -m) return -m;
      return v;
   endfunction

   function automatic longint slew_limit(input longint span);
      longint scaled;
      scaled = (longint'(rate_cfg) * span) >>> FRAC_BITS;
      return (scaled > STEP_MAX) ? STEP_MAX : scaled;
   endfunction

   function automatic projection_type project_steering(input steer_sample_type s);
      projection_type r;
      longint meas, comm, obs, dly, cmd, ctl, lim, age;
      longint cpt, pt, reach, now_bound, req, mc, cc;
      r    = '0;
      meas = $signed(s.measured);
      comm = $signed(s.committed);
      obs  = $signed(s.obs_age);
      dly  = $signed(s.delay);
      cmd  = $signed(s.cmd_age);
      ctl  = $signed(s.ctl_age);
      lim  = longint'(lim_cfg);
      age  = longint'(age_cfg);
      if (!s.present) begin
         r.status = STATUS_NO_COMMAND;
      end else if (obs < 0 || dly < 0) begin
         r.status = STATUS_BAD_TIMING;
      end else if (age == 0 || lim == 0 || cmd < 0 || ctl < 0) begin
         r.status = STATUS_BAD_LIMITS;
      end else if ((meas < 0 ? -meas : meas) > lim || (comm < 0 ? -comm : comm) > lim) begin
         r.status = STATUS_BAD_MEASURE;
      end else if (obs > age) begin
         r.status = STATUS_STALE;
      end else begin
         r.status = STATUS_OK;
      end
      if (r.status != STATUS_OK) return r;
      mc  = clamp_mag(meas, lim);
      cc  = clamp_mag(comm, lim);
      cpt = (obs < cmd) ? obs : cmd;
      pt  = cpt + dly;
      if (pt > TIME_MAX) pt = TIME_MAX;
      reach     = slew_limit(pt);
      now_bound = slew_limit(cpt);
      req       = cc - mc;
      r.measured_clamped        = ANGLE_BITS'(mc);
      r.committed_clamped       = ANGLE_BITS'(cc);
      r.current_angle           = ANGLE_BITS'(clamp_mag(mc + clamp_mag(req, now_bound), lim));
      r.origin_angle            = ANGLE_BITS'(clamp_mag(mc + clamp_mag(req, reach), lim));
      r.command_reached         = ((req < 0 ? -req : req) <= reach);
      r.command_projection_time = (TIME_BITS - 1)'(cpt);
      r.projection_time         = (TIME_BITS - 1)'(pt);
      r.max_reachable_step      = (ANGLE_BITS + 1)'(reach);
      return r;
   endfunction

   function automatic steer_sample_type make_sample(input int meas, comm, input bit present,
                                                    input int obs, dly, cmd, ctl);
      steer_sample_type s;
      s.measured  = ANGLE_BITS'(meas);
      s.committed = ANGLE_BITS'(comm);
      s.present   = present;
      s.obs_age   = TIME_BITS'(obs);
      s.delay     = TIME_BITS'(dly);
      s.cmd_age   = TIME_BITS'(cmd);
      s.ctl_age   = TIME_BITS'(ctl);
      return s;
   endfunction

   function automatic int pick_angle(input int lim);
      case ($urandom_range(5))
         0: return lim;
         1: return -lim;
         2: return 0;
         default: return int'($urandom_range(2 * lim)) - lim;
      endcase
   endfunction

   function automatic int pick_time(input int maxv);
      case ($urandom_range(5))
         0: return 0;
         1: return maxv;
         2: return $urandom_range((maxv < 64) ? maxv : 64);
         default: return $urandom_range(maxv);
      endcase
   endfunction

   function automatic steer_sample_type make_good_sample();
      steer_sample_type s;
      int lim, age, meas, comm;
      lim  = int'(lim_cfg);
      age  = int'(age_cfg);
      meas = pick_angle(lim);
      comm = pick_angle(lim);
      if ($urandom_range(3) == 0)
         comm = int'(clamp_mag(meas + int'($urandom_range(200)) - 100, lim));
      s = make_sample(meas, comm, 1'b1, pick_time(age),
                      pick_time($urandom_range(1) ? TIME_MAX : age),
                      pick_time($urandom_range(1) ? TIME_MAX : age), pick_time(TIME_MAX));
      return s;
   endfunction

   function automatic steer_sample_type make_broken_sample();
      steer_sample_type s;
      int lim, age, mag;
      s   = make_good_sample();
      lim = int'(lim_cfg);
      age = int'(age_cfg);
      case (break_kind_type'($urandom_range(6)))
         BREAK_ABSENT:    s.present = 1'b0;
         BREAK_OBS_NEG:   s.obs_age = TIME_BITS'(-(1 + int'($urandom_range(TIME_MAX))));
         BREAK_DELAY_NEG: s.delay   = TIME_BITS'(-(1 + int'($urandom_range(TIME_MAX))));
         BREAK_CMD_NEG:   s.cmd_age = TIME_BITS'(-(1 + int'($urandom_range(TIME_MAX))));
         BREAK_CTL_NEG:   s.ctl_age = TIME_BITS'(-(1 + int'($urandom_range(TIME_MAX))));
         BREAK_ANGLE: begin
            if (lim < ANGLE_MAX && $urandom_range(3) != 0) begin
               mag = lim + 1 + ($urandom_range(1) ? 0 : int'($urandom_range(ANGLE_MAX - lim - 1)));
               if ($urandom_range(1)) mag = -mag;
            end else begin
               mag = -ANGLE_MAX - 1;
            end
            if ($urandom_range(1)) s.measured = ANGLE_BITS'(mag);
            else s.committed = ANGLE_BITS'(mag);
         end
         BREAK_STALE: begin
            if (age < TIME_MAX)
               s.obs_age = TIME_BITS'(age + 1 +
                           ($urandom_range(1) ? 0 : int'($urandom_range(TIME_MAX - age - 1))));
         end
         default: ;
      endcase
      return s;
   endfunction

   function automatic steer_sample_type make_noise_sample();
      steer_sample_type s;
      s.measured  = ANGLE_BITS'($urandom);
      s.committed = ANGLE_BITS'($urandom);
      s.present   = 1'($urandom);
      s.obs_age   = TIME_BITS'($urandom);
      s.delay     = TIME_BITS'($urandom);
      s.cmd_age   = TIME_BITS'($urandom);
      s.ctl_age   = TIME_BITS'($urandom);
      return s;
   endfunction

   task automatic check_field(input string name, input logic signed [31:0] want, got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         faults++;
      end
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      case (idx)
         CSR_MAX_ABS_STEERING:    lim_cfg  = value[ANGLE_BITS-2:0];
         CSR_MAX_OBSERVATION_AGE: age_cfg  = value[TIME_BITS-2:0];
         CSR_MAX_STEERING_RATE:   rate_cfg = value[RATE_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic set_limits(input int abs_v, age_v, rate_v);
      write_reg(CSR_MAX_ABS_STEERING, CSR_DATA_BITS'(($urandom << (ANGLE_BITS - 1)) | abs_v));
      write_reg(CSR_MAX_OBSERVATION_AGE, CSR_DATA_BITS'(age_v));
      write_reg(CSR_MAX_STEERING_RATE, CSR_DATA_BITS'(($urandom << RATE_BITS) | rate_v));
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (sample_q.size() != 0 || req_if.valid || projection_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_phase(input int count, input int send_pct, input int take_pct);
      int roll;
      send_idle_pct = send_pct;
      take_idle_pct = take_pct;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(99);
         if (roll < 70) sample_q.push_back(make_good_sample());
         else if (roll < 85) sample_q.push_back(make_broken_sample());
         else sample_q.push_back(make_noise_sample());
      end
      wait_drained();
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         {req_if.measured_angle, req_if.committed_angle, req_if.committed_present,
          req_if.observation_age, req_if.prediction_delay, req_if.command_age,
          req_if.command_control_age} <= '0;
         send_gap <= 0;
      end else begin
         if (req_if.valid && req_if.ready) projection_q.push_back(project_steering(offered));
         if (req_if.valid && !req_if.ready) begin
            // hold the offered transaction
         end else if (send_gap > 0) begin
            send_gap     <= send_gap - 1;
            req_if.valid <= 1'b0;
         end else if (sample_q.size() != 0 && !calm && $urandom_range(99) < send_idle_pct) begin
            send_gap     <= $urandom_range(18);
            req_if.valid <= 1'b0;
         end else if (sample_q.size() != 0) begin
            offered = sample_q.pop_front();
            req_if.measured_angle      <= offered.measured;
            req_if.committed_angle     <= offered.committed;
            req_if.committed_present   <= offered.present;
            req_if.observation_age     <= offered.obs_age;
            req_if.prediction_delay    <= offered.delay;
            req_if.command_age         <= offered.cmd_age;
            req_if.command_control_age <= offered.ctl_age;
            req_if.valid               <= 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // response backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready   <= 1'b0;
         take_gap       <= 0;
         long_hold_left <= 0;
         long_hold_seen <= 0;
      end else if (long_hold_seen != long_hold_req) begin
         long_hold_seen <= long_hold_req;
         long_hold_left <= LONG_HOLD;
         rsp_if.ready   <= 1'b0;
      end else if (long_hold_left > 0) begin
         long_hold_left <= long_hold_left - 1;
         rsp_if.ready   <= 1'b0;
      end else if (take_gap > 0) begin
         take_gap     <= take_gap - 1;
         rsp_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(99) < take_idle_pct) begin
         take_gap     <= $urandom_range(18);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // response monitor
   always @(posedge clock) begin
      projection_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (projection_q.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual status %0d",
                     $time, rsp_if.status);
            faults++;
         end else begin
            want = projection_q.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_if.status));
            check_field("measured_clamped", 32'($signed(want.measured_clamped)),
                        32'(rsp_if.measured_clamped));
            check_field("committed_clamped", 32'($signed(want.committed_clamped)),
                        32'(rsp_if.committed_clamped));
            check_field("current_angle", 32'($signed(want.current_angle)),
                        32'(rsp_if.current_angle));
            check_field("origin_angle", 32'($signed(want.origin_angle)),
                        32'(rsp_if.origin_angle));
            check_field("command_reached", 32'(want.command_reached),
                        32'(rsp_if.command_reached));
            check_field("command_projection_time", 32'(want.command_projection_time),
                        32'(rsp_if.command_projection_time));
            check_field("projection_time", 32'(want.projection_time),
                        32'(rsp_if.projection_time));
            check_field("max_reachable_step", 32'(want.max_reachable_step),
                        32'(rsp_if.max_reachable_step));
         end
      end
   end

   initial begin
      reset        <= 1'b1;
      csr_if.valid <= 1'b0;
      csr_if.index <= CSR_MAX_ABS_STEERING;
      csr_if.data  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset limits: 8192 angle, 6554 age, rate 1024 (reach = time / 8)
      sample_q.push_back(make_sample(0, 100, 1'b0, 10, 10, 10, 10));
      sample_q.push_back(make_sample(0, 100, 1'b1, -1, 10, 10, 10));
      sample_q.push_back(make_sample(0, 100, 1'b1, 10, -TIME_MAX - 1, 10, 10));
      sample_q.push_back(make_sample(0, 100, 1'b1, 10, 10, -1, 10));
      sample_q.push_back(make_sample(0, 100, 1'b1, 10, 10, 10, -TIME_MAX - 1));
      sample_q.push_back(make_sample(-ANGLE_MAX - 1, 0, 1'b1, 10, 10, 10, 10));
      sample_q.push_back(make_sample(0, 8193, 1'b1, 10, 10, 10, 10));
      sample_q.push_back(make_sample(8192, -8192, 1'b1, 6554, 0, TIME_MAX, 0));
      sample_q.push_back(make_sample(0, 0, 1'b1, 6555, 0, 0, 0));
      sample_q.push_back(make_sample(0, 100, 1'b1, 800, 0, 800, 0));
      sample_q.push_back(make_sample(0, 100, 1'b1, 799, 0, 800, 0));
      sample_q.push_back(make_sample(100, -100, 1'b1, 0, 0, 0, 0));
      sample_q.push_back(make_sample(0, 8192, 1'b1, 6554, TIME_MAX, TIME_MAX, TIME_MAX));
      sample_q.push_back(make_sample(-8192, 8192, 1'b1, 100, 3000, 50, 0));
      sample_q.push_back(make_sample(ANGLE_MAX, ANGLE_MAX, 1'b1, TIME_MAX, TIME_MAX,
                                     TIME_MAX, TIME_MAX));
      sample_q.push_back(make_sample(0, 0, 1'b1, -TIME_MAX - 1, -TIME_MAX - 1,
                                     -TIME_MAX - 1, -TIME_MAX - 1));
      sample_q.push_back(make_sample(0, 0, 1'b0, -1, -1, -1, -1));
      sample_q.push_back(make_sample(-8192, 8191, 1'b1, 6554, 1, 6554, 5));
      sample_q.push_back(make_sample(9000, 0, 1'b1, 10, 10, -5, 10));
      sample_q.push_back(make_sample(9000, 0, 1'b1, 7000, 0, 0, 0));
      sample_q.push_back(make_sample(-300, 300, 1'b1, 6554, 2000, 4000, 1));
      wait_drained();

      // stall the response side while requests keep coming
      send_idle_pct = 0;
      take_idle_pct = 0;
      for (int i = 0; i < 80; i++) sample_q.push_back(make_good_sample());
      long_hold_req <= long_hold_req + 1;
      wait_drained();

      set_limits(ANGLE_MAX, TIME_MAX, 2 ** RATE_BITS - 1);
      run_phase(130, 20, 20);
      set_limits(1, 1, 0);
      run_phase(130, 0, 30);
      set_limits(0, 6554, 1024);
      run_phase(60, 30, 0);
      set_limits(8192, 0, 1024);
      run_phase(60, 10, 10);
      set_limits(4096, 100000, 7);
      run_phase(130, 25, 25);
      for (int p = 0; p < 3; p++) begin
         write_reg(CSR_UNUSED, CSR_DATA_BITS'($urandom));
         set_limits($urandom_range(ANGLE_MAX, 1), $urandom_range(TIME_MAX, 1),
                    $urandom_range(2 ** RATE_BITS - 1));
         run_phase(130, 5 + 15 * p, 35 - 15 * p);
      end
      set_limits(MAX_ABS_STEERING_RESET, MAX_OBSERVATION_AGE_RESET, MAX_STEERING_RATE_RESET);
      calm = 1'b1;
      run_phase(150, 0, 0);

      repeat (8) @(posedge clock);
      if (projection_q.size() != 0) begin
         $display("%0t: %0d results never arrived, expected empty, actual %0d",
                  $time, projection_q.size(), projection_q.size());
         faults++;
      end
      if (faults == 0) begin
         $display("steering_rate_limited_projection_top regression: pass");
      end else begin
         $display("steering_rate_limited_projection_top regression: fail");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("steering_rate_limited_projection_top regression: fail");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/srlp_pkg.sv
rtl/core/srlp_if.sv
rtl/core/srlp_reach.sv
rtl/core/steering_rate_limited_projection_top.sv
dv/tb.sv
